### hw/rtl/bemfac_pkg.sv
package bemfac_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 2;

  // Amplitudes at or above this level are treated as glitches and ignored.
  localparam logic [SampleW-1:0] AmpLimit = SampleW'(1000);
  localparam logic [CountW-1:0]  CountMax = '1;

  localparam logic [SampleW-1:0] ToneThrReset = SampleW'(100);
  localparam logic [SampleW-1:0] LeakThrReset = SampleW'(50);

  typedef enum logic [CfgIdxW-1:0] {
    CfgToneThr = 2'd0,
    CfgLeakThr = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               phase;
    logic               first;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] swing_count;
    logic              result_phase;
    logic              speaker_ok;
  } result_t;

  typedef struct packed {
    logic [SampleW-1:0] tone_thr;
    logic [SampleW-1:0] leak_thr;
  } thr_t;

endpackage

### hw/rtl/bemf_amplitude_checker_unit.sv
// Pipeline: two register stages (input register, then result register); the result is
// presented from the result register once the last sample has left the input register.
// Throughput: one sample per cycle while the input is not stalled.
// The input stalls only while a last sample is held behind a result that waits in the
// result register.
// Reset clears all tracking state and sets the thresholds to 100 and 50.
module bemf_amplitude_checker_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bemfac_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bemfac_pkg::SampleW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bemfac_pkg::SampleW-1:0] sample_i,
  input  logic                           phase_i,
  input  logic                           first_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bemfac_pkg::CountW-1:0]  swing_count_o,
  output logic                           result_phase_o,
  output logic                           speaker_ok_o
);
  import bemfac_pkg::*;

  thr_t    thr;
  item_t   item_d, item_q;
  logic    vld_d, vld_q;
  result_t res, res_d, res_q;
  logic    out_vld_d, out_vld_q;
  logic    out_free, step, in_acc;

  bemfac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  bemfac_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .thr_i  (thr),
    .res_o  (res)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  // A registered sample moves on unless it produces a result with nowhere to go.
  assign step       = vld_q && (!item_q.last || out_free);
  assign in_stall_o = vld_q && !step;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    item_d = item_q;
    vld_d  = vld_q && !step;
    if (in_acc) begin
      item_d.sample = sample_i;
      item_d.phase  = phase_i;
      item_d.first  = first_i;
      item_d.last   = last_i;
      vld_d         = 1'b1;
    end
  end

  always_comb begin
    res_d     = res_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (step && item_q.last) begin
      res_d     = res;
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_valid_o    = out_vld_q;
  assign swing_count_o  = res_q.swing_count;
  assign result_phase_o = res_q.result_phase;
  assign speaker_ok_o   = res_q.speaker_ok;

endmodule

### hw/rtl/bemfac_cfg_regs.sv
module bemfac_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bemfac_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bemfac_pkg::SampleW-1:0]     cfg_wdata_i,
  output bemfac_pkg::thr_t                   thr_o
);
  import bemfac_pkg::*;

  thr_t thr_d, thr_q;

  always_comb begin
    thr_d = thr_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgToneThr: thr_d.tone_thr = cfg_wdata_i;
        CfgLeakThr: thr_d.leak_thr = cfg_wdata_i;
        default:    thr_d = thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.tone_thr <= ToneThrReset;
      thr_q.leak_thr <= LeakThrReset;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

### hw/rtl/bemfac_track.sv
module bemfac_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bemfac_pkg::item_t   item_i,
  input  bemfac_pkg::thr_t    thr_i,
  output bemfac_pkg::result_t res_o
);
  import bemfac_pkg::*;

  logic [SampleW-1:0] prev_d, prev_q;
  logic [SampleW-1:0] valley_d, valley_q;
  logic               rising_d, rising_q;
  logic [CountW-1:0]  count_d, count_q;
  logic [CountW-1:0]  tone_d, tone_q;

  logic [SampleW-1:0] prev_eff, valley_eff, diff, thr;
  logic [CountW-1:0]  count_base, count_new;
  logic               peak, turn_up, amp_ok;

  always_comb begin
    // A first sample reloads the tracking registers, so no turn can occur on it.
    prev_eff   = item_i.first ? item_i.sample : prev_q;
    valley_eff = item_i.first ? item_i.sample : valley_q;
    count_base = item_i.first ? '0 : count_q;
    thr        = item_i.phase ? thr_i.leak_thr : thr_i.tone_thr;

    peak    = rising_q && (item_i.sample < prev_eff);
    turn_up = !rising_q && (item_i.sample > prev_eff);
    diff    = prev_eff - valley_eff;
    amp_ok  = peak && (prev_eff > valley_eff) && (diff < AmpLimit) && (diff > thr);

    count_new = (amp_ok && (count_base != CountMax)) ? count_base + CountW'(1) : count_base;

    res_o.swing_count  = count_new;
    res_o.result_phase = item_i.phase;
    res_o.speaker_ok   = item_i.phase && (tone_q > CountW'(1)) && (count_new == '0);
  end

  always_comb begin
    prev_d   = prev_q;
    valley_d = valley_q;
    rising_d = rising_q;
    count_d  = count_q;
    tone_d   = tone_q;
    if (step_i) begin
      prev_d   = item_i.sample;
      valley_d = turn_up ? prev_eff : valley_eff;
      if (peak) begin
        rising_d = 1'b0;
      end else if (turn_up) begin
        rising_d = 1'b1;
      end
      count_d = item_i.last ? '0 : count_new;
      if (item_i.last && !item_i.phase) begin
        tone_d = count_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      valley_q <= '0;
      rising_q <= 1'b0;
      count_q  <= '0;
      tone_q   <= '0;
    end else begin
      prev_q   <= prev_d;
      valley_q <= valley_d;
      rising_q <= rising_d;
      count_q  <= count_d;
      tone_q   <= tone_d;
    end
  end

endmodule
